@@ rtl/cosine_argument_reduce_f32_unit_macros.svh @@
// assertion macros shared by the checker
`ifndef COSINE_ARGUMENT_REDUCE_F32_UNIT_MACROS_SVH
`define COSINE_ARGUMENT_REDUCE_F32_UNIT_MACROS_SVH

// implication checked on every clock edge outside reset
`define CAR_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define CAR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/car_pkg.sv @@
`timescale 1ns / 1ps
package car_pkg;
	localparam int unsigned DataW = 32;
	localparam int unsigned Latency = 4;
	localparam logic [31:0] OneBits = 32'h3f800000;
	localparam logic [31:0] QnanBits = 32'h7fc00000;
	localparam logic [31:0] OneMinusUlp = 32'h3f7fffff;
	localparam logic [7:0] ExpBias = 8'd127;

	typedef enum logic [1:0] {
		RM_RNE = 2'd0,
		RM_RTZ = 2'd1,
		RM_RDN = 2'd2,
		RM_RUP = 2'd3
	} round_mode_t;

	// result classes decided in the decode stage
	typedef enum logic [2:0] {
		CL_PASS,
		CL_CONST,
		CL_SMALL,
		CL_FRAC
	} class_t;

	typedef struct packed {
		class_t      cls;
		logic [31:0] fixed_val;
		logic        neg;
		round_mode_t rm;
	} ctl_t;

	// index of the most significant set bit of a 24-bit word
	function automatic logic [4:0] msb24(input logic [23:0] v);
		logic [4:0] p;
		p = 5'd0;
		for (int i = 0; i < 24; i++) begin
			if (v[i]) p = 5'(i);
		end
		return p;
	endfunction
endpackage

@@ rtl/car_decode.sv @@
`timescale 1ns / 1ps
// classifies the word and forms the 24-bit or 64-bit magnitude to pack
module car_decode import car_pkg::*; (
	input  logic        [31:0] x_bits,
	input  round_mode_t        rm,
	output ctl_t               ctl,
	output logic        [63:0] small_n,
	output logic        [5:0]  small_s,
	output logic        [23:0] frac_n
);
	logic [7:0]  ef;
	logic [22:0] m;
	logic [7:0]  s;
	logic [4:0]  e;
	logic [1:0]  nlow;
	logic [23:0] frac;
	logic [47:0] sh;

	always_comb begin
		ef = x_bits[30:23];
		m = x_bits[22:0];
		s = ExpBias - ef;
		e = ef[4:0] - 5'd31; // ef-127 for ef in 127..151, low 5 bits
		ctl = '0;
		ctl.rm = rm;
		small_n = '0;
		small_s = '0;
		frac_n = '0;
		sh = '0;
		nlow = '0;
		frac = '0;
		if (ef == 8'hff) begin
			ctl.cls = CL_CONST;
			ctl.fixed_val = (m != '0) ? x_bits : QnanBits;
		end else if (ef == 8'd0 || ef > 8'd151) begin
			ctl.cls = CL_CONST;
			ctl.fixed_val = OneBits;
		end else if (ef < 8'd127) begin
			if (s > 8'd40) begin
				ctl.cls = CL_CONST;
				ctl.fixed_val = (rm == RM_RTZ || rm == RM_RDN) ? OneMinusUlp : OneBits;
			end else begin
				ctl.cls = CL_SMALL;
				small_s = s[5:0];
				small_n = (64'd1 << (7'd23 + 7'(s[5:0]))) - {40'd0, 1'b1, m};
			end
		end else begin
			ctl.cls = CL_FRAC;
			if (ef == 8'd151) begin
				nlow = {m[0], 1'b0};
				frac = '0;
			end else begin
				sh = {24'd0, 1'b1, m} << e;
				nlow = sh[24:23];
				frac = {1'b0, sh[22:0]};
			end
			unique case (nlow)
				2'd0: begin frac_n = 24'h800000 - frac; ctl.neg = 1'b0; end
				2'd1: begin frac_n = frac; ctl.neg = 1'b1; end
				2'd2: begin frac_n = 24'h800000 - frac; ctl.neg = 1'b1; end
				default: begin frac_n = frac; ctl.neg = 1'b0; end
			endcase
		end
	end
endmodule

@@ rtl/car_pack.sv @@
`timescale 1ns / 1ps
// normalization and rounding, split over two register stages
module car_pack import car_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        vld_in,
	input  ctl_t        ctl_in,
	input  logic [63:0] small_n,
	input  logic [5:0]  small_s,
	input  logic [23:0] frac_n,
	output logic        vld_out,
	output logic [31:0] res_out
);
	// stage a: normalize
	logic        vld_s3;
	ctl_t        ctl_s3;
	logic [24:0] q_s3;
	logic        half_s3, sticky_s3;
	logic [7:0]  exp_s3;
	logic [4:0]  fp;
	logic [63:0] nrm;

	always_comb begin
		// with s of one the difference fits in 24 bits and is exact
		fp = msb24((ctl_in.cls == CL_SMALL) ? small_n[23:0] : frac_n);
		// s above one: 1 - a lies in [2^-1, 1), top bit at 22+s
		nrm = small_n << (6'd41 - small_s);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		ctl_s3 <= ctl_in;
		if (ctl_in.cls == CL_SMALL && small_s != 6'd1) begin
			q_s3 <= {1'b0, nrm[63:40]};
			half_s3 <= nrm[39];
			sticky_s3 <= nrm[38:0] != '0;
			exp_s3 <= 8'd126;
		end else if (ctl_in.cls == CL_SMALL) begin
			q_s3 <= {1'b0, small_n[23:0] << (5'd23 - fp)};
			half_s3 <= 1'b0;
			sticky_s3 <= 1'b0;
			exp_s3 <= 8'(fp) + 8'd103;
		end else begin
			q_s3 <= {1'b0, frac_n << (5'd23 - fp)};
			half_s3 <= 1'b0;
			sticky_s3 <= 1'b0;
			exp_s3 <= 8'(fp) + 8'd104;
		end
	end

	// stage b: round and assemble
	logic [24:0] qr;
	logic [7:0]  er;
	logic        inc;
	logic [31:0] r;

	always_comb begin
		inc = 1'b0;
		unique case (ctl_s3.rm)
			RM_RNE: inc = half_s3 && (sticky_s3 || q_s3[0]);
			RM_RUP: inc = half_s3 || sticky_s3;
			default: inc = 1'b0;
		endcase
		if (ctl_s3.cls != CL_SMALL) inc = 1'b0;
		qr = q_s3 + 25'(inc);
		er = exp_s3;
		if (qr[24]) begin
			qr = qr >> 1;
			er = er + 8'd1;
		end
		unique case (ctl_s3.cls)
			CL_CONST, CL_PASS: r = ctl_s3.fixed_val;
			CL_SMALL: r = {1'b0, er, qr[22:0]};
			default: r = (q_s3[23:0] == '0) ? {ctl_s3.neg, 31'd0}
				: {ctl_s3.neg, er, qr[22:0]};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_out <= 1'b0;
		end else begin
			vld_out <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		res_out <= r;
	end
endmodule

@@ rtl/cosine_argument_reduce_f32_unit.sv @@
`timescale 1ns / 1ps
// done is start delayed through the valid registers vld_s1, vld_s2 and vld_s3
// throughput: one transaction per cycle, busy is held low
// stages: input register, decode, normalize, round and output register
// reset: arst_n asynchronous active low clears valid bits and round_mode to nearest-even
// the receiver cannot stall; each result is shown for one cycle with done
module cosine_argument_reduce_f32_unit import car_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [31:0] x_bits,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_wdata,
	output logic        done,
	output logic [31:0] result_bits
);
	// configuration register
	round_mode_t rm_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rm_q <= RM_RNE;
		end else if (cfg_we) begin
			rm_q <= round_mode_t'(cfg_wdata);
		end
	end

	// fully pipelined, never stalls
	assign busy = 1'b0;

	// stage 1: capture the operand
	logic        vld_s1;
	logic [31:0] x_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		x_s1 <= x_bits;
	end

	// stage 2: classify and form the unnormalized magnitude
	ctl_t        ctl_d;
	logic [63:0] small_d;
	logic [5:0]  s_d;
	logic [23:0] frac_d;

	car_decode u_dec (
		.x_bits (x_s1),
		.rm     (rm_q),
		.ctl    (ctl_d),
		.small_n(small_d),
		.small_s(s_d),
		.frac_n (frac_d)
	);

	logic        vld_s2;
	ctl_t        ctl_s2;
	logic [63:0] small_s2;
	logic [5:0]  s_s2;
	logic [23:0] frac_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		ctl_s2 <= ctl_d;
		small_s2 <= small_d;
		s_s2 <= s_d;
		frac_s2 <= frac_d;
	end

	// stages 3 and 4: normalize, round, pack
	car_pack u_pack (
		.clk    (clk),
		.arst_n (arst_n),
		.vld_in (vld_s2),
		.ctl_in (ctl_s2),
		.small_n(small_s2),
		.small_s(s_s2),
		.frac_n (frac_s2),
		.vld_out(done),
		.res_out(result_bits)
	);
endmodule

@@ rtl/cosine_argument_reduce_f32_unit_checker.sv @@
`timescale 1ns / 1ps
`include "cosine_argument_reduce_f32_unit_macros.svh"
module cosine_argument_reduce_f32_unit_assert import car_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic [31:0] result_bits
);
	`CAR_ASSERT_IMP(a_never_busy, clk, arst_n, 1'b1, !busy, "busy raised")
	`CAR_ASSERT_IMP(a_done_follows, clk, arst_n, done, $past(start, Latency), "done without start")
	`CAR_ASSERT_IMP(a_start_done, clk, arst_n, $past(start, Latency), done, "transaction lost")
	`CAR_ASSERT_IMP(a_range, clk, arst_n, done && result_bits[30:23] != 8'hff, result_bits[30:0] <= 31'h3f800000, "result out of range")
endmodule

bind cosine_argument_reduce_f32_unit cosine_argument_reduce_f32_unit_assert u_chk (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
	.done(done), .result_bits(result_bits)
);
